// File: rtl/core/frx_pkg.sv
`default_nettype none
package frx_pkg;

    localparam int BUFFER_DEPTH_DEF = 128;
    localparam int OUT_FIFO_DEPTH   = 3;

    localparam logic [7:0] HEADER_RESET  = 8'h55;
    localparam logic [6:0] MAX_LEN_RESET = 7'd80;
    localparam logic [7:0] LEN_POS       = 8'd5;
    localparam logic [8:0] LEN_EXTRA     = 9'd7;

    localparam logic CFG_HEADER  = 1'b0;
    localparam logic CFG_MAX_LEN = 1'b1;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_READ    = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RECV = 2'd1,
        ST_DONE = 2'd2
    } t_rx_state;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] byte_count;
        logic       frame_dropped;
        logic       frame_complete;
        logic [1:0] status;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage
`default_nettype wire

// File: rtl/core/frx_core.sv
`default_nettype none
module frx_core import frx_pkg::*; #(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_addr,
    input  wire logic [7:0] i_cfg_wdata,
    input  wire logic       i_accept,
    input  wire logic [1:0] i_kind,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic [6:0] i_read_index,
    output logic            o_valid,
    output t_result         o_result
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic [7:0] r_store [BUFFER_DEPTH];

    logic [7:0] r_header;
    logic [6:0] r_max_len;
    t_rx_state  r_state, n_state;
    logic [7:0] r_count, n_count;
    logic [7:0] r_pos0;
    logic [7:0] r_len;

    logic       r_s1_valid;
    t_rx_state  r_s1_state;
    logic       r_s1_complete;
    logic       r_s1_dropped;
    logic [7:0] r_s1_count;
    logic       r_s1_is_read;
    logic [7:0] r_rd_q;

    t_kind      kind;
    logic [7:0] cnt_inc;
    logic [7:0] len_val;
    logic [8:0] target;
    logic       have_len;
    logic       hit;
    logic       over;
    logic       start;
    logic       is_byte;
    logic       n_complete;
    logic       n_dropped;
    logic       wr_en;
    logic [6:0] wr_pos;

    assign kind     = t_kind'(i_kind);
    assign is_byte  = (kind == KIND_BYTE);
    assign cnt_inc  = r_count + 8'd1;
    assign len_val  = (r_count == LEN_POS) ? i_rx_byte : r_len;
    assign target   = {1'b0, len_val} + LEN_EXTRA;
    assign have_len = (cnt_inc > LEN_POS);
    assign hit      = have_len && (r_pos0 == r_header) && ({1'b0, cnt_inc} == target);
    assign over     = (have_len && ({1'b0, cnt_inc} > target)) || (cnt_inc > {1'b0, r_max_len});
    assign start    = (i_rx_byte == r_header);

    // next state
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (kind)
            KIND_BYTE: begin
                case (r_state)
                    ST_IDLE: begin
                        if (start) begin
                            n_state = ST_RECV;
                            n_count = 8'd1;
                        end
                    end
                    ST_RECV: begin
                        n_count = cnt_inc;
                        if (hit) begin
                            n_state = ST_DONE;
                        end else if (over) begin
                            n_state = ST_IDLE;
                            n_count = 8'd0;
                        end
                    end
                    default: begin
                        n_state = r_state;
                    end
                endcase
            end
            KIND_RELEASE: begin
                if (r_state == ST_DONE) begin
                    n_state = ST_IDLE;
                    n_count = 8'd0;
                end
            end
            default: begin
                n_state = r_state;
            end
        endcase
    end

    // outputs
    always_comb begin
        n_complete = 1'b0;
        n_dropped  = 1'b0;
        wr_en      = 1'b0;
        wr_pos     = r_count[6:0];
        case (r_state)
            ST_IDLE: begin
                wr_en  = is_byte && start;
                wr_pos = 7'd0;
            end
            ST_RECV: begin
                wr_en      = is_byte;
                n_complete = is_byte && hit;
                n_dropped  = is_byte && !hit && over;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header  <= HEADER_RESET;
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_HEADER) begin
                r_header <= i_cfg_wdata;
            end else if (i_cfg_addr == CFG_MAX_LEN) begin
                r_max_len <= i_cfg_wdata[6:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= 8'd0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
            if (i_accept) begin
                r_state <= n_state;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_state    <= n_state;
            r_s1_complete <= n_complete;
            r_s1_dropped  <= n_dropped;
            r_s1_count    <= n_count;
            r_s1_is_read  <= (kind == KIND_READ);
            if (wr_en && (wr_pos == 7'd0)) begin
                r_pos0 <= i_rx_byte;
            end
            if (wr_en && ({1'b0, wr_pos} == LEN_POS)) begin
                r_len <= i_rx_byte;
            end
        end
    end

    // frame buffer
    always_ff @(posedge i_clk) begin
        if (i_accept && wr_en) begin
            r_store[{{(AW-7){1'b0}}, wr_pos}] <= i_rx_byte;
        end
        if (i_accept && (kind == KIND_READ)) begin
            r_rd_q <= r_store[{{(AW-7){1'b0}}, i_read_index}];
        end
    end

    assign o_valid                 = r_s1_valid;
    assign o_result.status         = r_s1_state;
    assign o_result.frame_complete = r_s1_complete;
    assign o_result.frame_dropped  = r_s1_dropped;
    assign o_result.byte_count     = r_s1_count;
    assign o_result.read_data      = r_s1_is_read ? r_rd_q : 8'd0;

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> !(r_s1_complete && r_s1_dropped))
        else $error("complete and dropped together");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_count == 8'd0))
        else $error("count nonzero while idle");

    a_complete_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_complete) |-> (r_s1_state == ST_DONE))
        else $error("completed frame not held");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_state == ST_DONE && kind == KIND_BYTE) |=> $stable(r_count))
        else $error("count moved on a held frame");

endmodule
`default_nettype wire

// File: rtl/core/frx_out_fifo.sv
`default_nettype none
module frx_out_fifo import frx_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_result  i_data,
    input  wire logic     i_pop,
    output logic          o_valid,
    output t_result       o_data,
    output logic [1:0]    o_count
);

    t_result    r_mem [OUT_FIFO_DEPTH];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [1:0] r_cnt;
    logic       pop;

    localparam logic [1:0] LAST = 2'(OUT_FIFO_DEPTH - 1);

    assign pop     = i_pop && (r_cnt != 2'd0);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? 2'd0 : r_wr_ptr + 2'd1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? 2'd0 : r_rd_ptr + 2'd1;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == LAST + 2'd1) |-> (!i_push || pop))
        else $error("result queue overflow");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr <= LAST) && (r_rd_ptr <= LAST))
        else $error("queue pointer out of range");

endmodule
`default_nettype wire

// File: rtl/core/header_length_frame_receiver.sv
`default_nettype none
// channel   dir  handshake                          payload
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tdata rx_byte, read_index; tuser kind
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tdata status .. read_data
// cfg       in   i_cfg_we (no wait)                 i_cfg_addr, i_cfg_wdata
//
// one word accepted per cycle while tready is high; its result passes through the result register
// (with the registered buffer read) and then through the result queue before it can be taken
// tready drops while the three-entry result queue and the result register hold three words
// reset is synchronous; the frame buffer is not cleared and needs no sweep
module header_length_frame_receiver import frx_pkg::*; #(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,  // rx_byte[7:0], read_index[14:8], zero
    input  wire logic [1:0]  i_s_axis_tuser,  // kind[1:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,  // status[1:0], frame_complete[2],
                                              // frame_dropped[3], byte_count[11:4],
                                              // read_data[19:12], zero
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [7:0]  i_cfg_wdata
);

    logic    accept;
    logic    s1_valid;
    t_result s1_result;
    t_result q_data;
    logic    q_valid;
    logic [1:0] q_count;

    assign o_s_axis_tready = ({1'b0, q_count} + {2'b0, s1_valid}) < 3'(OUT_FIFO_DEPTH);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    frx_core #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_kind      (i_s_axis_tuser),
        .i_rx_byte   (i_s_axis_tdata[7:0]),
        .i_read_index(i_s_axis_tdata[14:8]),
        .o_valid     (s1_valid),
        .o_result    (s1_result)
    );

    frx_out_fifo u_out_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (s1_valid),
        .i_data (s1_result),
        .i_pop  (i_m_axis_tready),
        .o_valid(q_valid),
        .o_data (q_data),
        .o_count(q_count)
    );

    assign o_m_axis_tvalid = q_valid;
    assign o_m_axis_tdata  = {{(24 - RESULT_W){1'b0}}, q_data};

endmodule
`default_nettype wire
